/* rtl/core/uer_pkg.sv */
package uer_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd0;
	localparam logic [1:0] REG_MIN_DISTANCE  = 2'd1;
	localparam logic [1:0] REG_MAX_DISTANCE  = 2'd2;
	localparam logic [1:0] REG_TRIGGER_TICKS = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Field widths
	localparam int TIMEOUT_W = 16;
	localparam int TRIG_W    = 8;
	localparam int DIST_W    = 10;
	localparam int WIDTH_W   = 16;

	// Reset values of the registers
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd30000;
	localparam logic [DIST_W-1:0]    MIN_RST     = 10'd2;
	localparam logic [DIST_W-1:0]    MAX_RST     = 10'd400;
	localparam logic [TRIG_W-1:0]    TRIG_RST    = 8'd10;

	// Ticks of trigger low before the high pulse
	localparam int PRE_LOW_TICKS = 2;

	// Divide by 58 as (w * 72316) >> 22, exact for any 16-bit w
	localparam int RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] RECIP_58 = 17'd72316;
	localparam int RECIP_SHIFT = 22;
	localparam int PROD_W      = WIDTH_W + RECIP_W;
	localparam int QUOT_W      = 11;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_PRELOW = 3'd1,
		PH_TRIG   = 3'd2,
		PH_RISE   = 3'd3,
		PH_PULSE  = 3'd4
	} phase_t;

	// One classified tick handed from front to back
	typedef struct packed {
		logic               trig;
		logic               done;
		logic [WIDTH_W-1:0] width;
	} tick_rec_t;

endpackage

/* rtl/core/uer_in_if.sv */
interface uer_in_if;
	logic valid;
	logic ready;
	logic echo_level;
	logic start_request;

	modport source(output valid, output echo_level, output start_request, input ready);
	modport sink(input valid, input echo_level, input start_request, output ready);
endinterface

/* rtl/core/uer_out_if.sv */
interface uer_out_if;
	logic                          valid;
	logic                          ready;
	logic                          trigger_level;
	logic                          done_res;
	logic [uer_pkg::DIST_W-1:0]    range_cm;
	logic                          in_range_led;

	modport source(output valid, output trigger_level, output done_res, output range_cm,
		output in_range_led, input ready);
	modport sink(input valid, input trigger_level, input done_res, input range_cm,
		input in_range_led, output ready);
endinterface

/* rtl/core/uer_front.sv */
module uer_front #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	uer_in_if.sink                            sample,
	input  logic [uer_pkg::TIMEOUT_W-1:0]     timeout_ticks,
	input  logic [uer_pkg::TRIG_W-1:0]        trigger_ticks,
	input  logic                              full,
	output logic                              push,
	output uer_pkg::tick_rec_t                rec
);

	localparam int CMP_W = (COUNT_WIDTH > uer_pkg::TIMEOUT_W) ? COUNT_WIDTH : uer_pkg::TIMEOUT_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

	uer_pkg::phase_t          phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]   tick_q, tick_d;
	logic [COUNT_WIDTH-1:0]   pulse_q, pulse_d;
	logic [COUNT_WIDTH-1:0]   tick_inc, pulse_inc, tlen;
	logic [CMP_W-1:0]         timeout_x;
	logic                     accept;

	assign sample.ready = !full;
	assign accept       = sample.valid && !full;
	assign push         = accept;

	assign tick_inc  = tick_q + ONE;
	assign pulse_inc = pulse_q + ONE;
	assign timeout_x = CMP_W'(timeout_ticks);
	// a trigger length of zero runs as one tick
	assign tlen = (trigger_ticks == '0) ? ONE : COUNT_WIDTH'(trigger_ticks);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_IDLE;
			tick_q  <= '0;
			pulse_q <= '0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			pulse_q <= pulse_d;
		end
	end

	// Sequencer: one step per accepted tick
	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		pulse_d   = pulse_q;
		rec.trig  = 1'b0;
		rec.done  = 1'b0;
		rec.width = '0;
		if (accept) begin
			case (phase_q)
				uer_pkg::PH_IDLE: begin
					if (sample.start_request) begin
						phase_d = uer_pkg::PH_PRELOW;
						tick_d  = '0;
						pulse_d = '0;
					end
				end
				uer_pkg::PH_PRELOW: begin
					tick_d = tick_inc;
					if (tick_inc >= COUNT_WIDTH'(uer_pkg::PRE_LOW_TICKS)) begin
						phase_d = uer_pkg::PH_TRIG;
						tick_d  = '0;
					end
				end
				uer_pkg::PH_TRIG: begin
					rec.trig = 1'b1;
					tick_d   = tick_inc;
					if (tick_inc >= tlen) begin
						phase_d = uer_pkg::PH_RISE;
						tick_d  = '0;
					end
				end
				uer_pkg::PH_RISE: begin
					if (sample.echo_level) begin
						phase_d = uer_pkg::PH_PULSE;
						pulse_d = ONE;
						// zero timeout fails every pulse
						if (timeout_ticks == '0) begin
							rec.done = 1'b1;
							phase_d  = uer_pkg::PH_IDLE;
							tick_d   = '0;
							pulse_d  = '0;
						end
					end else begin
						tick_d = tick_inc;
						if (CMP_W'(tick_inc) >= timeout_x || tick_inc == COUNT_MAX) begin
							rec.done = 1'b1;
							phase_d  = uer_pkg::PH_IDLE;
							tick_d   = '0;
							pulse_d  = '0;
						end
					end
				end
				uer_pkg::PH_PULSE: begin
					if (sample.echo_level) begin
						pulse_d = pulse_inc;
						if (CMP_W'(pulse_inc) > timeout_x || pulse_inc == COUNT_MAX) begin
							rec.done = 1'b1;
							phase_d  = uer_pkg::PH_IDLE;
							tick_d   = '0;
							pulse_d  = '0;
						end
					end else begin
						// width never exceeds timeout_ticks, so it fits the field
						rec.done  = 1'b1;
						rec.width = uer_pkg::WIDTH_W'(pulse_q);
						phase_d   = uer_pkg::PH_IDLE;
						tick_d    = '0;
						pulse_d   = '0;
					end
				end
				default: begin
					phase_d = uer_pkg::PH_IDLE;
					tick_d  = '0;
					pulse_d = '0;
				end
			endcase
		end
	end

endmodule

/* rtl/core/uer_queue.sv */
module uer_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  uer_pkg::tick_rec_t                push_rec,
	output logic                              full,
	input  logic                              pop,
	output uer_pkg::tick_rec_t                pop_rec,
	output logic                              empty
);

	uer_pkg::tick_rec_t              mem_q [uer_pkg::QUEUE_DEPTH];
	logic [uer_pkg::QPTR_W-1:0]      wr_q, rd_q;
	logic [uer_pkg::QCNT_W-1:0]      cnt_q;
	logic                            do_push, do_pop;

	assign full    = (cnt_q == uer_pkg::QCNT_W'(uer_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_rec = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_rec;
	end

endmodule

/* rtl/core/uer_back.sv */
module uer_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              empty,
	input  uer_pkg::tick_rec_t                pop_rec,
	output logic                              pop,
	input  logic [uer_pkg::DIST_W-1:0]        min_distance,
	input  logic [uer_pkg::DIST_W-1:0]        max_distance,
	uer_out_if.source                         result
);

	logic                              valid_s1;
	logic                              trig_s1, done_s1;
	logic [uer_pkg::PROD_W-1:0]        prod_s1;
	logic                              valid_q, trig_q, done_q;
	logic [uer_pkg::DIST_W-1:0]        dist_q;
	logic [uer_pkg::QUOT_W-1:0]        quot;
	logic                              in_window;
	logic                              out_adv, s1_adv;

	// Output slot frees if idle or taken; stage 1 moves if idle or slot frees
	assign out_adv = !valid_q || result.ready;
	assign s1_adv  = !valid_s1 || out_adv;
	assign pop     = s1_adv && !empty;

	// Stage 1: reciprocal multiply for the divide by 58
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			trig_s1 <= pop_rec.trig;
			done_s1 <= pop_rec.done;
			prod_s1 <= uer_pkg::PROD_W'(pop_rec.width) * uer_pkg::PROD_W'(uer_pkg::RECIP_58);
		end
	end

	// Window check on the quotient
	assign quot      = prod_s1[uer_pkg::RECIP_SHIFT +: uer_pkg::QUOT_W];
	assign in_window = (quot >= uer_pkg::QUOT_W'(min_distance))
		&& (quot <= uer_pkg::QUOT_W'(max_distance));

	// Output register; dist_q also holds the last stored distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dist_q  <= '0;
		end else if (out_adv) begin
			valid_q <= valid_s1;
			if (valid_s1 && done_s1) begin
				dist_q <= in_window ? quot[uer_pkg::DIST_W-1:0] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			trig_q <= trig_s1;
			done_q <= done_s1;
		end
	end

	assign result.valid         = valid_q;
	assign result.trigger_level = trig_q;
	assign result.done_res      = done_q;
	assign result.range_cm      = dist_q;
	assign result.in_range_led  = (dist_q != '0);

endmodule

/* rtl/core/ultrasonic_echo_ranger_unit.sv */
// Ultrasonic echo ranger.
// Channel "sample" takes one request per microsecond tick: the echo pin
// level and a start request. Channel "result" returns one request per
// sample: trigger pin level, a done pulse, the held distance in cm and an
// in-range LED. A start while idle drives the trigger low for 2 ticks, high
// for trigger_ticks ticks, then times the echo pulse; width / 58 outside
// [min_distance, max_distance], a missing rise or an overlong pulse gives 0.
// Path: queue write on the accepting edge, multiply stage, output register.
// Throughput: one sample per cycle while the queue has room; the front
// sequencer steps once per tick and the back end multiplies once per
// request, both fully pipelined.
// A stalled result channel fills the 4-entry queue, after which sample.ready
// drops; nothing is lost or repeated.
// Reset: sequencer idle, counters and held distance zero, registers at
// 30000 / 2 / 400 / 10. Write them through cfg_we/cfg_index/cfg_wdata,
// only while no measurement is in flight; the block does not check this.
module ultrasonic_echo_ranger_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	uer_in_if.sink                               sample,
	uer_out_if.source                            result,
	input  logic                                 cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	logic [uer_pkg::TIMEOUT_W-1:0]   timeout_q;
	logic [uer_pkg::DIST_W-1:0]      min_q, max_q;
	logic [uer_pkg::TRIG_W-1:0]      trig_len_q;
	logic                            q_push, q_full, q_pop, q_empty;
	uer_pkg::tick_rec_t              push_rec, pop_rec;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= uer_pkg::TIMEOUT_RST;
			min_q      <= uer_pkg::MIN_RST;
			max_q      <= uer_pkg::MAX_RST;
			trig_len_q <= uer_pkg::TRIG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				uer_pkg::REG_TIMEOUT_TICKS: timeout_q  <= cfg_wdata[uer_pkg::TIMEOUT_W-1:0];
				uer_pkg::REG_MIN_DISTANCE:  min_q      <= cfg_wdata[uer_pkg::DIST_W-1:0];
				uer_pkg::REG_MAX_DISTANCE:  max_q      <= cfg_wdata[uer_pkg::DIST_W-1:0];
				uer_pkg::REG_TRIGGER_TICKS: trig_len_q <= cfg_wdata[uer_pkg::TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	uer_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.timeout_ticks(timeout_q),
		.trigger_ticks(trig_len_q),
		.full         (q_full),
		.push         (q_push),
		.rec          (push_rec)
	);

	uer_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_rec(push_rec),
		.full    (q_full),
		.pop     (q_pop),
		.pop_rec (pop_rec),
		.empty   (q_empty)
	);

	uer_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (q_empty),
		.pop_rec     (pop_rec),
		.pop         (q_pop),
		.min_distance(min_q),
		.max_distance(max_q),
		.result      (result)
	);

	// A measurement cannot finish during a trigger-high tick
	a_trig_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.trigger_level |-> !result.done_res)
		else $error("done reported during trigger pulse");

	// LED follows the held distance
	a_led_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.in_range_led == (result.range_cm != '0)))
		else $error("in-range LED disagrees with distance");

	// Held distance only changes on a delivered done
	a_dist_held: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready ##1 !(result.valid && result.done_res)
		|-> $stable(result.range_cm))
		else $error("distance changed without a done");

	// A queue entry is waiting whenever input is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> !q_empty)
		else $error("input stalled with empty queue");

endmodule
